/* sv/sfrs_pkg.sv */
// Package with shared types, widths and codes of the shooter fire/reload sequencer.
package sfrs_pkg;

  // Widths of the tick count and of the distance field.
  localparam int unsigned TICK_COUNT_WIDTH = 16;
  localparam int unsigned DISTANCE_WIDTH   = 16;

  // Width of the configuration write data and of the register index.
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CLASS_W    = 3;

  // Compare widths that hold both operands without loss.
  localparam int unsigned TIMEOUT_CMP_W =
      (TICK_COUNT_WIDTH > CFG_DATA_W) ? TICK_COUNT_WIDTH : CFG_DATA_W;
  localparam int unsigned WINDOW_W =
      ((DISTANCE_WIDTH > RANGE_W) ? DISTANCE_WIDTH : RANGE_W) + 1;

  // Packed stream widths.
  localparam int unsigned IN_BITS   = 3 + DISTANCE_WIDTH + CLASS_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = SPEED_W + 3;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned ACTION_W   = 2;

  // Reset values of the timing and drive registers.
  localparam logic [CFG_DATA_W-1:0] FIRE_TIMEOUT_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RELOAD_TIMEOUT_RST = 16'd150;
  localparam logic [SPEED_W-1:0]    MOTOR_SPEED_RST    = 8'd255;

  // Saturation value of the tick count.
  localparam logic [TICK_COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_CHECKED = 2'd1,
    ACT_FORCED  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_BACK_HALF = 3'd0,
    REG_RANGE_HALF      = 3'd1,
    REG_RANGE_FULL      = 3'd2,
    REG_RANGE_STILL     = 3'd3,
    REG_RANGE_TOL       = 3'd4,
    REG_FIRE_TIMEOUT    = 3'd5,
    REG_RELOAD_TIMEOUT  = 3'd6,
    REG_MOTOR_SPEED     = 3'd7
  } reg_idx_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_BACK_HALF = 3'd0,
    CLS_HALF      = 3'd1,
    CLS_FULL      = 3'd2,
    CLS_STILL     = 3'd3
  } speed_class_e;

  // One accepted input item.
  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic                      manual_mode;
    logic                      fire_button;
    logic                      limit_switch;
    logic [DISTANCE_WIDTH-1:0] distance;
    logic [CLASS_W-1:0]        speed_class;
  } item_t;

endpackage

/* sv/shooter_fire_reload_sequencer_top.sv */
// Top level of the shooter fire/reload sequencer: input register, update logic, result register.
// An accepted item is held in the input register; its result is written to the output
// register, raising m_axis_tvalid_o, once that register is free or being taken.
// Throughput: one item per cycle if not stalled; the flag and count update is one compare stage.
// The output register and the input register decouple the sides, so a stalled result
// still lets one more item in. Reset (rst_ni low, asynchronous) clears the flags, the
// count, the applied drive, both valid bits and sets the registers to their reset values.
module shooter_fire_reload_sequencer_top
  import sfrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // Fields from bit 0 up: manual_mode, fire_button, limit_switch, distance, speed_class.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: action.
  input  logic [ACTION_W-1:0]   s_axis_tuser_i,
  // Result stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // Fields from bit 0 up: motor_drive, is_running, is_ready, shot_granted.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Configuration registers.
  logic [RANGE_W-1:0]    range_back_half_q, range_half_q, range_full_q, range_still_q;
  logic [RANGE_W-1:0]    range_tol_q;
  logic [CFG_DATA_W-1:0] fire_timeout_q, reload_timeout_q;
  logic [SPEED_W-1:0]    motor_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_back_half_q <= '0;
      range_half_q      <= '0;
      range_full_q      <= '0;
      range_still_q     <= '0;
      range_tol_q       <= '0;
      fire_timeout_q    <= FIRE_TIMEOUT_RST;
      reload_timeout_q  <= RELOAD_TIMEOUT_RST;
      motor_speed_q     <= MOTOR_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RANGE_BACK_HALF: range_back_half_q <= cfg_wdata_i[RANGE_W-1:0];
        REG_RANGE_HALF:      range_half_q      <= cfg_wdata_i[RANGE_W-1:0];
        REG_RANGE_FULL:      range_full_q      <= cfg_wdata_i[RANGE_W-1:0];
        REG_RANGE_STILL:     range_still_q     <= cfg_wdata_i[RANGE_W-1:0];
        REG_RANGE_TOL:       range_tol_q       <= cfg_wdata_i[RANGE_W-1:0];
        REG_FIRE_TIMEOUT:    fire_timeout_q    <= cfg_wdata_i;
        REG_RELOAD_TIMEOUT:  reload_timeout_q  <= cfg_wdata_i;
        REG_MOTOR_SPEED:     motor_speed_q     <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the update stage moves when the result register is free or being taken.
  logic  in_valid_q, out_valid_q;
  logic  advance;
  item_t item_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.action       <= s_axis_tuser_i;
      item_q.manual_mode  <= s_axis_tdata_i[0];
      item_q.fire_button  <= s_axis_tdata_i[1];
      item_q.limit_switch <= s_axis_tdata_i[2];
      item_q.distance     <= s_axis_tdata_i[3 +: DISTANCE_WIDTH];
      item_q.speed_class  <= s_axis_tdata_i[3+DISTANCE_WIDTH +: CLASS_W];
    end
  end

  // Sequencer state.
  logic                        running_q, running_d;
  logic                        ready_q, ready_d;
  logic [TICK_COUNT_WIDTH-1:0] count_q, count_d;
  logic [SPEED_W-1:0]          drive_q, drive_d;
  logic                        granted;

  // Optimal distance for the current speed class; other classes give zero.
  logic [RANGE_W-1:0] class_range;
  always_comb begin
    unique case (item_q.speed_class)
      CLS_BACK_HALF: class_range = range_back_half_q;
      CLS_HALF:      class_range = range_half_q;
      CLS_FULL:      class_range = range_full_q;
      CLS_STILL:     class_range = range_still_q;
      default:       class_range = '0;
    endcase
  end

  // Distance window, strict on both sides and without wrap.
  logic [WINDOW_W-1:0] dist_ext, range_ext, tol_ext;
  logic                win_hi_ok, win_lo_ok, in_window;
  assign dist_ext  = WINDOW_W'(item_q.distance);
  assign range_ext = WINDOW_W'(class_range);
  assign tol_ext   = WINDOW_W'(range_tol_q);
  assign win_hi_ok = dist_ext < (range_ext + tol_ext);
  assign win_lo_ok = (tol_ext > range_ext) || (dist_ext > (range_ext - tol_ext));
  assign in_window = win_hi_ok && win_lo_ok;

  // Tick count after the saturating increment, and the timeout checks on it.
  logic [TICK_COUNT_WIDTH-1:0] count_inc;
  logic                        fire_expired, reload_expired;
  assign count_inc      = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  assign fire_expired   = TIMEOUT_CMP_W'(count_inc) > TIMEOUT_CMP_W'(fire_timeout_q);
  assign reload_expired = TIMEOUT_CMP_W'(count_inc) > TIMEOUT_CMP_W'(reload_timeout_q);

  // Next state for the item in the input register.
  always_comb begin
    running_d = running_q;
    ready_d   = ready_q;
    count_d   = count_q;
    drive_d   = drive_q;
    granted   = 1'b0;
    unique case (item_q.action)
      ACT_TICK: begin
        if (item_q.manual_mode) begin
          drive_d   = item_q.fire_button ? motor_speed_q : '0;
          running_d = 1'b0;
          ready_d   = item_q.limit_switch;
        end else begin
          count_d = count_inc;
          if (running_q) begin
            if (ready_q) begin
              if (!item_q.limit_switch || fire_expired) begin
                ready_d   = 1'b0;
                running_d = 1'b0;
              end
            end else if (item_q.limit_switch || reload_expired) begin
              ready_d   = item_q.limit_switch;
              running_d = 1'b0;
            end
          end
          drive_d = running_d ? motor_speed_q : '0;
        end
      end
      ACT_CHECKED: begin
        granted = !ready_q || in_window;
        if (granted && !running_q) begin
          running_d = 1'b1;
          count_d   = '0;
        end
      end
      ACT_FORCED: begin
        if (!running_q) begin
          running_d = 1'b1;
          count_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      ready_q   <= 1'b0;
      count_q   <= '0;
      drive_q   <= '0;
    end else if (advance) begin
      running_q <= running_d;
      ready_q   <= ready_d;
      count_q   <= count_d;
      drive_q   <= drive_d;
    end
  end

  // Result register.
  logic [OUT_BITS-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= {granted, ready_d, running_d, drive_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(result_q);

endmodule

/* sv/sfrs_checker.sv */
// Port-level checker for the shooter fire/reload sequencer and its bind statement.
module sfrs_checker
  import sfrs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // A granted shot always leaves a cycle running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[SPEED_W+2]) |-> m_axis_tdata_o[SPEED_W])
    else $error("shot granted without a running cycle");

  // The input side is never held off while the result side is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while output is free");

  // An item accepted while the output is free must lead to a valid result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o) |-> ##2 m_axis_tvalid_o)
    else $error("accepted item produced no result");

endmodule

bind shooter_fire_reload_sequencer_top sfrs_checker u_sfrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* tb/shooter_fire_reload_sequencer_top_tb.sv */
// Self-checking testbench of the shooter fire/reload sequencer: random and directed items.
module shooter_fire_reload_sequencer_top_tb;
  import sfrs_pkg::*;

  // Action code that the block must treat as a no-op.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Speed classes without a programmed range.
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN_LO  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN_MID = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN_HI  = 3'd7;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned PRINT_CAP    = 50;

  // One result item as it appears in m_axis_tdata_o, motor_drive in the lowest bits.
  typedef struct packed {
    logic               shot_granted;
    logic               is_ready;
    logic               is_running;
    logic [SPEED_W-1:0] motor_drive;
  } result_t;

  // Tracks the sequencer state and holds the results still to come.
  class shot_scoreboard;
    logic [RANGE_W-1:0]          range_tab [4];
    logic [RANGE_W-1:0]          tolerance;
    logic [CFG_DATA_W-1:0]       fire_limit;
    logic [CFG_DATA_W-1:0]       reload_limit;
    logic [SPEED_W-1:0]          speed;
    logic                        running;
    logic                        ready;
    logic [TICK_COUNT_WIDTH-1:0] ticks;
    logic [SPEED_W-1:0]          drive;
    result_t                     pending_q [$];
    int unsigned                 errors;

    function new();
      foreach (range_tab[i]) range_tab[i] = '0;
      tolerance    = '0;
      fire_limit   = FIRE_TIMEOUT_RST;
      reload_limit = RELOAD_TIMEOUT_RST;
      speed        = MOTOR_SPEED_RST;
      running      = 1'b0;
      ready        = 1'b0;
      ticks        = '0;
      drive        = '0;
      errors       = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RANGE_BACK_HALF: range_tab[2'(CLS_BACK_HALF)] = val;
        REG_RANGE_HALF:      range_tab[2'(CLS_HALF)]      = val;
        REG_RANGE_FULL:      range_tab[2'(CLS_FULL)]      = val;
        REG_RANGE_STILL:     range_tab[2'(CLS_STILL)]     = val;
        REG_RANGE_TOL:       tolerance                    = val;
        REG_FIRE_TIMEOUT:    fire_limit                   = val;
        REG_RELOAD_TIMEOUT:  reload_limit                 = val;
        default:             speed                        = val[SPEED_W-1:0];
      endcase
    endfunction

    // Classes above the still class have no optimal distance.
    function logic [RANGE_W-1:0] class_range(logic [CLASS_W-1:0] cls);
      if (cls <= CLS_STILL) return range_tab[cls[1:0]];
      return '0;
    endfunction

    function void start_cycle();
      if (!running) begin
        running = 1'b1;
        ticks   = '0;
      end
    endfunction

    // Advance the sequencer by one accepted item and queue the result it causes.
    function void note_input(logic [IN_DATA_W-1:0] data, logic [ACTION_W-1:0] act);
      logic                      manual;
      logic                      button;
      logic                      limit;
      logic [DISTANCE_WIDTH-1:0] dist_val;
      logic [CLASS_W-1:0]        cls;
      logic                      granted;
      int                        r;
      int                        t;
      int                        d;
      result_t                   res;
      manual   = data[0];
      button   = data[1];
      limit    = data[2];
      dist_val = data[3 +: DISTANCE_WIDTH];
      cls      = data[3 + DISTANCE_WIDTH +: CLASS_W];
      granted  = 1'b0;
      case (act)
        ACT_TICK: begin
          if (manual) begin
            drive   = button ? speed : '0;
            running = 1'b0;
            ready   = limit;
          end else begin
            if (ticks != COUNT_MAX) ticks = ticks + 1'b1;
            if (running) begin
              // A firing cycle ends on limit release or timeout, a reload cycle on limit close or timeout.
              if (ready) begin
                if (!limit || ticks > fire_limit) begin
                  ready   = 1'b0;
                  running = 1'b0;
                end
              end else if (limit || ticks > reload_limit) begin
                ready   = limit;
                running = 1'b0;
              end
            end
            drive = running ? speed : '0;
          end
        end
        ACT_CHECKED: begin
          if (!ready) begin
            granted = 1'b1;
          end else begin
            r = int'(class_range(cls));
            t = int'(tolerance);
            d = int'(dist_val);
            granted = (d < r + t) && (d > r - t);
          end
          if (granted) start_cycle();
        end
        ACT_FORCED: start_cycle();
        default: ;
      endcase
      res.motor_drive  = drive;
      res.is_running   = running;
      res.is_ready     = ready;
      res.shot_granted = granted;
      pending_q.push_back(res);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("ERROR %s: got %0d, expected %0d", what, got, want);
    endtask

    // Compare one accepted result with the oldest expectation, field by field.
    task check_result(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[OUT_BITS-1:0]);
      if (pending_q.size() == 0) begin
        report("result with nothing expected", 16'(got), 16'd0);
      end else begin
        want = pending_q.pop_front();
        if (got.motor_drive !== want.motor_drive)
          report("motor_drive", 16'(got.motor_drive), 16'(want.motor_drive));
        if (got.is_running !== want.is_running)
          report("is_running", 16'(got.is_running), 16'(want.is_running));
        if (got.is_ready !== want.is_ready)
          report("is_ready", 16'(got.is_ready), 16'(want.is_ready));
        if (got.shot_granted !== want.shot_granted)
          report("shot_granted", 16'(got.shot_granted), 16'(want.shot_granted));
      end
    endtask
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [ACTION_W-1:0]   s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  shot_scoreboard sb;
  bit             no_idle      = 1'b0;
  logic           limit_level  = 1'b0;
  int unsigned    hold_req     = 0;
  int unsigned    hold_seen    = 0;
  int unsigned    hold_left    = 0;
  int unsigned    rx_idle_left = 0;
  int unsigned    stall_cycles = 0;

  shooter_fire_reload_sequencer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Note accepted inputs and check accepted results at the edge that moves them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_input(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_idle_left != 0) begin
      rx_idle_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(0, 3);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("shooter_fire_reload_sequencer_top: mismatch");
      $finish;
    end
  end

  function automatic item_t mk(logic [ACTION_W-1:0] act, logic manual, logic button,
                               logic limit, logic [DISTANCE_WIDTH-1:0] dist_val,
                               logic [CLASS_W-1:0] cls);
    item_t it;
    it.action       = act;
    it.manual_mode  = manual;
    it.fire_button  = button;
    it.limit_switch = limit;
    it.distance     = dist_val;
    it.speed_class  = cls;
    return it;
  endfunction

  // Mostly automatic-mode items with a slowly toggling limit switch and distances
  // clustered around the window edges, so that cycles start, run and end often.
  function automatic item_t gen_item();
    item_t       it;
    int unsigned pick;
    int          tol;
    int          d;
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.action = ACT_TICK;
    else if (pick < 77) it.action = ACT_CHECKED;
    else if (pick < 94) it.action = ACT_FORCED;
    else                it.action = ACT_UNUSED;
    it.manual_mode = ($urandom_range(0, 9) == 0);
    it.fire_button = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) limit_level = ~limit_level;
    it.limit_switch = ($urandom_range(0, 19) == 0) ? ~limit_level : limit_level;
    it.speed_class = ($urandom_range(0, 4) == 0) ? CLASS_W'($urandom_range(0, 7))
                                                 : CLASS_W'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 6) begin
      tol = int'(sb.tolerance);
      d = int'(sb.class_range(it.speed_class)) + int'($urandom_range(0, 2 * tol + 4))
          - tol - 2;
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      it.distance = DISTANCE_WIDTH'(d);
    end else begin
      it.distance = DISTANCE_WIDTH'($urandom());
    end
    return it;
  endfunction

  // Offer one item until it is taken, then maybe leave a gap.
  task automatic send_item(input item_t it);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({it.speed_class, it.distance, it.limit_switch,
                                   it.fire_button, it.manual_mode});
    s_axis_tuser_i  <= it.action;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_item(gen_item());
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Drain the block, then program every register.
  task automatic apply_setting(input logic [15:0] rb, rh, rf, rs, tol, fire, reload,
                               input logic [7:0] spd);
    wait_drained();
    write_reg(REG_RANGE_BACK_HALF, rb);
    write_reg(REG_RANGE_HALF, rh);
    write_reg(REG_RANGE_FULL, rf);
    write_reg(REG_RANGE_STILL, rs);
    write_reg(REG_RANGE_TOL, tol);
    write_reg(REG_FIRE_TIMEOUT, fire);
    write_reg(REG_RELOAD_TIMEOUT, reload);
    write_reg(REG_MOTOR_SPEED, 16'(spd));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: cycle starts and ends, window edges, manual mode, odd codes.
    apply_setting(16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd100, 16'd3, 16'd5, 8'd200);
    send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'd0, CLS_BACK_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b0, 16'd0, CLS_UNKNOWN_HI));
    send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b1, 16'd0, CLS_BACK_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd900, CLS_BACK_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd1100, CLS_BACK_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd2099, CLS_HALF));
    send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b1, 16'd0, CLS_HALF));
    send_item(mk(ACT_FORCED, 1'b0, 1'b0, 1'b1, 16'd0, CLS_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd4000, CLS_STILL));
    // Firing cycle runs into its timeout with the limit still closed.
    repeat (3) send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b1, 16'd0, CLS_FULL));
    // Reload cycle runs into its timeout with the limit open.
    send_item(mk(ACT_FORCED, 1'b0, 1'b0, 1'b0, 16'd0, CLS_FULL));
    repeat (6) send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'd0, CLS_FULL));
    // Manual mode follows the button and copies the limit switch.
    send_item(mk(ACT_TICK, 1'b1, 1'b1, 1'b1, 16'd0, CLS_FULL));
    send_item(mk(ACT_TICK, 1'b1, 1'b0, 1'b0, 16'd0, CLS_FULL));
    send_item(mk(ACT_TICK, 1'b1, 1'b1, 1'b1, 16'd0, CLS_FULL));
    // Unknown classes use range zero.
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd100, CLS_UNKNOWN_LO));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b0, 1'b1, 16'd99, CLS_UNKNOWN_MID));
    send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b0, 16'd0, CLS_BACK_HALF));
    send_item(mk(ACT_CHECKED, 1'b0, 1'b1, 1'b1, 16'hFFFF, CLS_FULL));
    send_item(mk(ACT_UNUSED, 1'b1, 1'b1, 1'b1, 16'hFFFF, CLS_UNKNOWN_HI));
    send_random(230);

    // Lowest register values: timeouts of zero and an empty window.
    apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_random(230);

    // Highest register values.
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  8'hFF);
    send_random(230);

    // One long firing cycle with the limit held closed, ended only by its timeout.
    apply_setting(16'd10, 16'd20, 16'd30, 16'd40, 16'd5, 16'd30, 16'hFFFF, 8'd1);
    send_item(mk(ACT_TICK, 1'b1, 1'b0, 1'b1, 16'd0, CLS_STILL));
    send_item(mk(ACT_FORCED, 1'b0, 1'b0, 1'b1, 16'd0, CLS_STILL));
    repeat (34) send_item(mk(ACT_TICK, 1'b0, 1'b0, 1'b1, 16'd0, CLS_STILL));

    // Random setting; the receiver holds off while items keep coming.
    apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom_range(0, 300)), 16'($urandom_range(1, 20)),
                  16'($urandom_range(1, 30)), 8'($urandom()));
    send_random(20);
    hold_req++;
    send_random(220);

    // Window of exactly one distance value.
    apply_setting(16'd500, 16'd0, 16'd65535, 16'd1234, 16'd1, 16'd10, 16'd10, 8'd128);
    send_random(230);

    // Last part without any idling.
    apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom_range(0, 2000)), 16'($urandom_range(0, 8)),
                  16'($urandom_range(0, 8)), 8'($urandom()));
    no_idle = 1'b1;
    send_random(230);

    wait_drained();
    if (sb.errors == 0) begin
      $display("shooter_fire_reload_sequencer_top: match");
    end else begin
      $display("shooter_fire_reload_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
